/* rtl/nbb_pkg.sv */
// nbb_pkg: shared constants for the normalized box blur block
// port field widths, command codes, register indexes and parameter defaults
// no dependencies
package nbb_pkg;

    // parameter defaults
    localparam int MAX_SIDE_DEF    = 256;
    localparam int MAX_RADIUS_DEF  = 8;
    localparam int SAMPLE_BITS_DEF = 16;

    // field widths
    localparam int CMD_W    = 2;
    localparam int HSAMP_W  = 16;
    localparam int COORD_W  = 8;
    localparam int RES_W    = 18;
    localparam int GAIN_W   = 10;
    localparam int SPAN_W   = 8;
    localparam int RADIUS_W = 4;
    localparam int FRAC_W   = 8;

    // window coordinate width, signed, holds coordinate plus or minus the radius
    localparam int WIN_W = 10;

    // stream port widths
    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = 1;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_SPAN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLEND_RADIUS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_GAIN  = 2'd2;

    localparam logic [SPAN_W-1:0]   GRID_SPAN_RST    = 8'd255;
    localparam logic [RADIUS_W-1:0] BLEND_RADIUS_RST = 4'd2;
    localparam logic [GAIN_W-1:0]   HEIGHT_GAIN_RST  = 10'd100;

    // commands
    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    // saturated result
    localparam logic [RES_W-1:0] RES_MAX = {RES_W{1'b1}};

endpackage

/* rtl/normalized_box_blur.sv */
// normalized_box_blur: top level, sample grid memory, window sequencer,
// shared multiplier and restoring divider
// depends on nbb_pkg
//
// Loads a square grid of height samples, tracks the lowest and highest sample,
// and answers a query with the clamp-to-edge box mean of a (2r+1) x (2r+1)
// window, normalized by the extremes and scaled by height_gain (unsigned Q10.8,
// truncated, saturated to 0..262143). A load, a clear or an unused command is
// taken while the sequencer is idle. A query on a flat grid goes straight to
// the result. Any other query reads n = (2r+1)^2 window samples: the single
// read port of the sample memory delivers one window sample per cycle, then
// the shared multiplier runs three products and the restoring divider runs
// 19 steps. A query whose mean lies at or below the lowest sample skips the
// gain product and divider; a saturating one stops at the first divider step.
// A query also waits while an earlier result still sits in the output
// register. The input is not ready while a query is in work; a finished result
// waits in the output register while loads are taken. The sample memory is
// not cleared after reset; every sample must be loaded before it is queried.
module normalized_box_blur #(
    parameter int MAX_SIDE    = nbb_pkg::MAX_SIDE_DEF,
    parameter int MAX_RADIUS  = nbb_pkg::MAX_RADIUS_DEF,
    parameter int SAMPLE_BITS = nbb_pkg::SAMPLE_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration write port
    input  logic                            cfg_wr_en,
    input  logic [nbb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [nbb_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // input channel
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // height_sample[15:0], column[23:16], row[31:24]
    input  logic [nbb_pkg::S_TDATA_W-1:0]   s_tdata,
    // command[1:0]
    input  logic [nbb_pkg::S_TUSER_W-1:0]   s_tuser,
    // result channel
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // smoothed_height[17:0], zero[23:18]
    output logic [nbb_pkg::M_TDATA_W-1:0]   m_tdata,
    // flat_grid[0]
    output logic [nbb_pkg::M_TUSER_W-1:0]   m_tuser
);
    import nbb_pkg::*;

    localparam int DEPTH    = MAX_SIDE * MAX_SIDE;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int R_W      = $clog2(MAX_RADIUS + 1);
    localparam int SIDE_MAX = 2 * MAX_RADIUS + 1;
    localparam int D_W      = $clog2(SIDE_MAX + 1);
    localparam int N_MAX    = SIDE_MAX * SIDE_MAX;
    localparam int N_W      = $clog2(N_MAX + 1);
    localparam int SUM_W    = SAMPLE_BITS + N_W;
    localparam int DEN_W    = N_W + SAMPLE_BITS;
    localparam int MA_W     = SUM_W;
    localparam int MB_W     = (SAMPLE_BITS > GAIN_W) ? SAMPLE_BITS : GAIN_W;
    localparam int P_W      = MA_W + MB_W;
    localparam int NUM_W    = SUM_W + GAIN_W + FRAC_W;
    localparam int DSR_W    = DEN_W + RES_W;
    localparam int DIV_W    = (NUM_W > DSR_W) ? NUM_W : DSR_W;
    localparam int STEP_W   = $clog2(RES_W + 1);

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_WIN   = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_SUB   = 3'd3;
    localparam logic [2:0] S_MG    = 3'd4;
    localparam logic [2:0] S_NUM   = 3'd5;
    localparam logic [2:0] S_DIV   = 3'd6;
    localparam logic [2:0] S_FIN   = 3'd7;

    // configuration and extremes
    logic [SPAN_W-1:0]      grid_span_reg;
    logic [RADIUS_W-1:0]    blend_radius_reg;
    logic [GAIN_W-1:0]      height_gain_reg;
    logic [SAMPLE_BITS-1:0] lowest_reg, lowest_next;
    logic [SAMPLE_BITS-1:0] highest_reg, highest_next;

    // sequencer and datapath registers
    logic [2:0]             state_reg, state_next;
    logic [COORD_W-1:0]     col_reg, col_next;
    logic [COORD_W-1:0]     row_reg, row_next;
    logic [R_W-1:0]         rad_reg, rad_next;
    logic [D_W-1:0]         last_reg, last_next;
    logic [D_W-1:0]         dx_reg, dx_next;
    logic [D_W-1:0]         dy_reg, dy_next;
    logic [N_W-1:0]         n_reg, n_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic                   rd_valid_reg, rd_valid_next;
    logic [SAMPLE_BITS-1:0] rd_data_reg;
    logic [P_W-1:0]         prod_reg;
    logic [DEN_W-1:0]       den_reg, den_next;
    logic [SUM_W-1:0]       diff_reg, diff_next;
    logic [DIV_W-1:0]       rem_reg, rem_next;
    logic [DIV_W-1:0]       dsr_reg, dsr_next;
    logic [RES_W-1:0]       quo_reg, quo_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic [RES_W-1:0]       res_height_reg, res_height_next;
    logic                   res_flat_reg, res_flat_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [RES_W-1:0]       m_height_reg, m_height_next;
    logic                   m_flat_reg, m_flat_next;

    // sample memory
    logic [SAMPLE_BITS-1:0] mem [DEPTH];
    logic                   mem_we;
    logic [ADDR_W-1:0]      wr_addr;
    logic [ADDR_W-1:0]      rd_addr;

    // shared multiplier
    logic                   mul_en;
    logic [MA_W-1:0]        mul_a;
    logic [MB_W-1:0]        mul_b;

    // input fields
    logic [CMD_W-1:0]       in_cmd;
    logic [SAMPLE_BITS-1:0] in_sample;
    logic [COORD_W-1:0]     in_col, in_row;
    logic                   in_fire;

    // clamped coordinates and limits
    logic [SPAN_W-1:0]      span;
    logic [R_W-1:0]         rad_lim;
    logic [COORD_W-1:0]     col_c, row_c;
    logic signed [WIN_W-1:0] wx, wy, span_s;
    logic [COORD_W-1:0]     tx, ty;

    // divider step
    logic [DIV_W:0]         trial;
    logic                   trial_ge;

    assign in_cmd    = s_tuser[CMD_W-1:0];
    assign in_sample = SAMPLE_BITS'(s_tdata[HSAMP_W-1:0]);
    assign in_col    = s_tdata[HSAMP_W +: COORD_W];
    assign in_row    = s_tdata[HSAMP_W+COORD_W +: COORD_W];
    assign s_tready  = (state_reg == S_IDLE);
    assign in_fire   = s_tvalid && s_tready;

    // effective span and radius
    assign span    = (int'(grid_span_reg) > MAX_SIDE - 1) ? SPAN_W'(MAX_SIDE - 1)
                                                          : grid_span_reg;
    assign rad_lim = (int'(blend_radius_reg) > MAX_RADIUS) ? R_W'(MAX_RADIUS)
                                                           : R_W'(blend_radius_reg);
    assign col_c   = (in_col > span) ? span : in_col;
    assign row_c   = (in_row > span) ? span : in_row;

    // window neighbor coordinates, clamped to the grid edge
    assign span_s = $signed(WIN_W'(span));
    assign wx = $signed(WIN_W'(col_reg) + WIN_W'(dx_reg) - WIN_W'(rad_reg));
    assign wy = $signed(WIN_W'(row_reg) + WIN_W'(dy_reg) - WIN_W'(rad_reg));

    always_comb begin
        if (wx < 0) begin
            tx = '0;
        end else if (wx > span_s) begin
            tx = span;
        end else begin
            tx = wx[COORD_W-1:0];
        end
        if (wy < 0) begin
            ty = '0;
        end else if (wy > span_s) begin
            ty = span;
        end else begin
            ty = wy[COORD_W-1:0];
        end
    end

    // row-major addressing
    assign wr_addr = ADDR_W'(row_c) * ADDR_W'(MAX_SIDE) + ADDR_W'(col_c);
    assign rd_addr = ADDR_W'(ty) * ADDR_W'(MAX_SIDE) + ADDR_W'(tx);
    assign mem_we  = in_fire && (in_cmd == CMD_LOAD);

    // sample memory, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_addr] <= in_sample;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // shared multiplier operand select
    always_comb begin
        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        unique case (state_reg)
            S_DRAIN: begin
                mul_a = MA_W'(n_reg);
                mul_b = MB_W'(lowest_reg);
            end
            S_SUB: begin
                mul_a = MA_W'(n_reg);
                mul_b = MB_W'(highest_reg - lowest_reg);
            end
            S_MG: begin
                mul_a = diff_reg;
                mul_b = MB_W'(height_gain_reg);
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mul_en) begin
            prod_reg <= P_W'(mul_a) * P_W'(mul_b);
        end
    end

    // restoring divider trial subtraction
    assign trial    = {1'b0, rem_reg} - {1'b0, dsr_reg};
    assign trial_ge = !trial[DIV_W];

    // sequencer
    always_comb begin
        state_next      = state_reg;
        lowest_next     = lowest_reg;
        highest_next    = highest_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        rad_next        = rad_reg;
        last_next       = last_reg;
        dx_next         = dx_reg;
        dy_next         = dy_reg;
        n_next          = n_reg;
        sum_next        = sum_reg;
        rd_valid_next   = (state_reg == S_WIN);
        den_next        = den_reg;
        diff_next       = diff_reg;
        rem_next        = rem_reg;
        dsr_next        = dsr_reg;
        quo_next        = quo_reg;
        step_next       = step_reg;
        res_height_next = res_height_reg;
        res_flat_next   = res_flat_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_height_next   = m_height_reg;
        m_flat_next     = m_flat_reg;

        // output register drains on a result transaction
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        // window accumulation, one sample behind the read address
        if (rd_valid_reg) begin
            sum_next = sum_reg + SUM_W'(rd_data_reg);
        end

        unique case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    unique case (in_cmd)
                        CMD_LOAD: begin
                            if (in_sample < lowest_reg) begin
                                lowest_next = in_sample;
                            end
                            if (in_sample > highest_reg) begin
                                highest_next = in_sample;
                            end
                        end
                        CMD_CLEAR: begin
                            lowest_next  = {SAMPLE_BITS{1'b1}};
                            highest_next = '0;
                        end
                        CMD_QUERY: begin
                            col_next  = col_c;
                            row_next  = row_c;
                            rad_next  = rad_lim;
                            last_next = D_W'({rad_lim, 1'b0});
                            dx_next   = '0;
                            dy_next   = '0;
                            n_next    = '0;
                            sum_next  = '0;
                            if (highest_reg <= lowest_reg) begin
                                res_height_next = '0;
                                res_flat_next   = 1'b1;
                                state_next      = S_FIN;
                            end else begin
                                state_next = S_WIN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_WIN: begin
                n_next = n_reg + N_W'(1);
                if (dy_reg == last_reg) begin
                    dy_next = '0;
                    if (dx_reg == last_reg) begin
                        state_next = S_DRAIN;
                    end else begin
                        dx_next = dx_reg + D_W'(1);
                    end
                end else begin
                    dy_next = dy_reg + D_W'(1);
                end
            end
            S_DRAIN: begin
                // last sample lands in the sum, multiplier forms n * lowest
                state_next = S_SUB;
            end
            S_SUB: begin
                // multiplier forms n * (highest - lowest)
                if (P_W'(sum_reg) > prod_reg) begin
                    diff_next  = sum_reg - prod_reg[SUM_W-1:0];
                    state_next = S_MG;
                end else begin
                    res_height_next = '0;
                    res_flat_next   = 1'b0;
                    state_next      = S_FIN;
                end
            end
            S_MG: begin
                // multiplier forms diff * gain
                den_next   = prod_reg[DEN_W-1:0];
                state_next = S_NUM;
            end
            S_NUM: begin
                rem_next   = DIV_W'({prod_reg[SUM_W+GAIN_W-1:0], {FRAC_W{1'b0}}});
                dsr_next   = DIV_W'({den_reg, {RES_W{1'b0}}});
                quo_next   = '0;
                step_next  = STEP_W'(RES_W);
                state_next = S_DIV;
            end
            S_DIV: begin
                dsr_next = dsr_reg >> 1;
                if (step_reg == STEP_W'(RES_W)) begin
                    // quotient would need more than the result width
                    if (trial_ge) begin
                        res_height_next = RES_MAX;
                        res_flat_next   = 1'b0;
                        state_next      = S_FIN;
                    end
                    step_next = step_reg - STEP_W'(1);
                end else begin
                    quo_next = {quo_reg[RES_W-2:0], trial_ge};
                    if (trial_ge) begin
                        rem_next = trial[DIV_W-1:0];
                    end
                    if (step_reg == '0) begin
                        res_height_next = {quo_reg[RES_W-2:0], trial_ge};
                        res_flat_next   = 1'b0;
                        state_next      = S_FIN;
                    end else begin
                        step_next = step_reg - STEP_W'(1);
                    end
                end
            end
            S_FIN: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_height_next = res_height_reg;
                    m_flat_next   = res_flat_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            rd_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
            lowest_reg   <= {SAMPLE_BITS{1'b1}};
            highest_reg  <= '0;
        end else begin
            state_reg    <= state_next;
            rd_valid_reg <= rd_valid_next;
            m_tvalid_reg <= m_tvalid_next;
            lowest_reg   <= lowest_next;
            highest_reg  <= highest_next;
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_span_reg    <= GRID_SPAN_RST;
            blend_radius_reg <= BLEND_RADIUS_RST;
            height_gain_reg  <= HEIGHT_GAIN_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_GRID_SPAN:    grid_span_reg    <= cfg_wdata[SPAN_W-1:0];
                CFG_BLEND_RADIUS: blend_radius_reg <= cfg_wdata[RADIUS_W-1:0];
                CFG_HEIGHT_GAIN:  height_gain_reg  <= cfg_wdata[GAIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        col_reg        <= col_next;
        row_reg        <= row_next;
        rad_reg        <= rad_next;
        last_reg       <= last_next;
        dx_reg         <= dx_next;
        dy_reg         <= dy_next;
        n_reg          <= n_next;
        sum_reg        <= sum_next;
        den_reg        <= den_next;
        diff_reg       <= diff_next;
        rem_reg        <= rem_next;
        dsr_reg        <= dsr_next;
        quo_reg        <= quo_next;
        step_reg       <= step_next;
        res_height_reg <= res_height_next;
        res_flat_reg   <= res_flat_next;
        m_height_reg   <= m_height_next;
        m_flat_reg     <= m_flat_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'(m_height_reg);
    assign m_tuser  = M_TUSER_W'(m_flat_reg);

endmodule

/* rtl/nbb_checker.sv */
// nbb_checker: port-level checks for normalized_box_blur, with its bind
// depends on nbb_pkg and the normalized_box_blur top level
module nbb_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [nbb_pkg::S_TUSER_W-1:0]   s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [nbb_pkg::M_TDATA_W-1:0]   m_tdata,
    input logic [nbb_pkg::M_TUSER_W-1:0]   m_tuser
);
    import nbb_pkg::*;

    // a stalled result holds its payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // a flat grid result carries a zero height
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("flat grid result with nonzero height");

    // an accepted query keeps the input side busy
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == CMD_QUERY |=> !s_tready)
        else $error("input ready right after a query transaction");

    // a new result only appears at the end of query work
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared while input side was idle");

endmodule

bind normalized_box_blur nbb_checker u_nbb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
